/* design/tasj_pkg.sv */
// ----------------------------------------------------------------------------
// tasj_pkg
// Shared sizes and types for the timestamp aligned stream join unit.
// ----------------------------------------------------------------------------
package tasj_pkg;

	localparam int PORTS      = 3;
	localparam int FIFO_DEPTH = 16;
	localparam int DATA_W     = 32;
	localparam int TIME_W     = 32;

	localparam int PORT_W = 2;
	localparam int PTR_W  = $clog2(FIFO_DEPTH);
	localparam int FILL_W = $clog2(FIFO_DEPTH + 1);

	typedef logic [DATA_W-1:0] data_t;
	typedef logic [TIME_W-1:0] time_t;
	typedef logic [PTR_W-1:0]  ptr_t;
	typedef logic [FILL_W-1:0] fill_t;

	// result kinds
	localparam logic KIND_TUPLE = 1'b0;
	localparam logic KIND_DROP  = 1'b1;

	function automatic ptr_t ptr_next(input ptr_t p);
		ptr_t r;
		if (p == ptr_t'(FIFO_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + ptr_t'(1);
		end
		return r;
	endfunction

endpackage

/* design/timestamp_aligned_stream_join_unit.sv */
// ----------------------------------------------------------------------------
// timestamp_aligned_stream_join_unit
// Per-port sample FIFOs; joins heads at the smallest timestamp, reports drops.
// ----------------------------------------------------------------------------
//
//  channel | signals                                          | direction
//  --------+--------------------------------------------------+----------
//  in      | in_valid, in_stall, port_index, sample_value,    | to block
//          | sample_time                                      |
//  out     | out_valid, out_stall, result_kind, arg_zero,      | from block
//          | arg_one, arg_two, matched_mask, tuple_time       |
//
// One request per cycle while no held result stalls the stage. A request is
// registered in the input stage, then append, min-find over the three heads
// and pop happen in the same cycle and load the result register, from which
// the result is offered on the out channel.
// Reset clears the fill counts, pointers and valid flags; FIFO storage is
// not cleared. A held result stalls the input stage, which in turn stalls
// the input channel; requests that give no result still need the stage.
module timestamp_aligned_stream_join_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [tasj_pkg::PORT_W-1:0] port_index,
	input  tasj_pkg::data_t             sample_value,
	input  tasj_pkg::time_t             sample_time,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        result_kind,
	output tasj_pkg::data_t             arg_zero,
	output tasj_pkg::data_t             arg_one,
	output tasj_pkg::data_t             arg_two,
	output logic [tasj_pkg::PORTS-1:0]  matched_mask,
	output tasj_pkg::time_t             tuple_time
);

	// input stage
	logic                        valid_s1;
	logic [tasj_pkg::PORT_W-1:0] port_s1;
	tasj_pkg::data_t             value_s1;
	tasj_pkg::time_t             time_s1;

	// FIFO state; storage lives in one small register file per port
	tasj_pkg::fill_t fill_q   [tasj_pkg::PORTS];
	tasj_pkg::ptr_t  head_q   [tasj_pkg::PORTS];
	tasj_pkg::ptr_t  tail_q   [tasj_pkg::PORTS];

	tasj_pkg::data_t [tasj_pkg::PORTS-1:0] stored_val;
	tasj_pkg::time_t [tasj_pkg::PORTS-1:0] stored_time;

	// result register
	logic                       out_valid_q;
	logic                       kind_q;
	tasj_pkg::data_t            args_q [tasj_pkg::PORTS];
	logic [tasj_pkg::PORTS-1:0] mask_q;
	tasj_pkg::time_t            tmin_q;

	logic                       advance;
	logic                       in_range;
	logic                       full_hit;
	logic                       append;
	logic                       drop;
	logic                       join_ok;
	logic                       produce;
	logic [tasj_pkg::PORTS-1:0] app_vec;
	logic [tasj_pkg::PORTS-1:0] pop_vec;
	logic [tasj_pkg::PORTS-1:0] nonempty;
	tasj_pkg::time_t            head_time [tasj_pkg::PORTS];
	tasj_pkg::data_t            head_val  [tasj_pkg::PORTS];
	tasj_pkg::data_t            args_d    [tasj_pkg::PORTS];
	tasj_pkg::time_t            tmin;

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign produce  = join_ok || drop;

	always_comb begin
		in_range = (port_s1 < tasj_pkg::PORT_W'(tasj_pkg::PORTS));
		full_hit = 1'b0;
		for (int i = 0; i < tasj_pkg::PORTS; i++) begin
			if (port_s1 == tasj_pkg::PORT_W'(i) &&
					fill_q[i] == tasj_pkg::FILL_W'(tasj_pkg::FIFO_DEPTH)) begin
				full_hit = 1'b1;
			end
		end
		append = advance && in_range && !full_hit;
		drop   = advance && in_range && full_hit;

		// an empty FIFO that takes this sample has it as its head
		for (int i = 0; i < tasj_pkg::PORTS; i++) begin
			app_vec[i]  = append && (port_s1 == tasj_pkg::PORT_W'(i));
			nonempty[i] = (fill_q[i] != '0) || app_vec[i];
			if (fill_q[i] == '0) begin
				head_time[i] = time_s1;
				head_val[i]  = value_s1;
			end else begin
				head_time[i] = stored_time[i];
				head_val[i]  = stored_val[i];
			end
		end
		join_ok = append && (&nonempty);

		tmin = head_time[0];
		for (int i = 1; i < tasj_pkg::PORTS; i++) begin
			if (head_time[i] < tmin) begin
				tmin = head_time[i];
			end
		end

		for (int i = 0; i < tasj_pkg::PORTS; i++) begin
			pop_vec[i] = join_ok && (head_time[i] == tmin);
			args_d[i]  = pop_vec[i] ? head_val[i] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			port_s1  <= port_index;
			value_s1 <= sample_value;
			time_s1  <= sample_time;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < tasj_pkg::PORTS; i++) begin
				fill_q[i] <= '0;
				head_q[i] <= '0;
				tail_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < tasj_pkg::PORTS; i++) begin
				if (app_vec[i] && !pop_vec[i]) begin
					fill_q[i] <= fill_q[i] + tasj_pkg::FILL_W'(1);
				end else if (!app_vec[i] && pop_vec[i]) begin
					fill_q[i] <= fill_q[i] - tasj_pkg::FILL_W'(1);
				end
				if (app_vec[i]) begin
					tail_q[i] <= tasj_pkg::ptr_next(tail_q[i]);
				end
				if (pop_vec[i]) begin
					head_q[i] <= tasj_pkg::ptr_next(head_q[i]);
				end
			end
		end
	end

	for (genvar i = 0; i < tasj_pkg::PORTS; i++) begin : g_port
		tasj_pkg::data_t values_q [tasj_pkg::FIFO_DEPTH];
		tasj_pkg::time_t times_q  [tasj_pkg::FIFO_DEPTH];

		always_ff @(posedge clk) begin
			if (app_vec[i]) begin
				values_q[tail_q[i]] <= value_s1;
				times_q[tail_q[i]]  <= time_s1;
			end
		end

		assign stored_val[i]  = values_q[head_q[i]];
		assign stored_time[i] = times_q[head_q[i]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= produce;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && produce) begin
			if (drop) begin
				kind_q <= tasj_pkg::KIND_DROP;
				mask_q <= '0;
				tmin_q <= '0;
				for (int i = 0; i < tasj_pkg::PORTS; i++) begin
					args_q[i] <= '0;
				end
			end else begin
				kind_q <= tasj_pkg::KIND_TUPLE;
				mask_q <= pop_vec;
				tmin_q <= tmin;
				for (int i = 0; i < tasj_pkg::PORTS; i++) begin
					args_q[i] <= args_d[i];
				end
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign result_kind  = kind_q;
	assign arg_zero     = args_q[0];
	assign arg_one      = args_q[1];
	assign arg_two      = args_q[2];
	assign matched_mask = mask_q;
	assign tuple_time   = tmin_q;

endmodule
